FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the color converter; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/rgb2yuv_pkg.sv
// Package with shared constants, types and coefficient helpers for the converter.
`default_nettype none

package rgb2yuv_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int PIX_W = 8;
    localparam int IN_W  = 12 * PIX_W;
    localparam int OUT_W = 6 * PIX_W;

    // Coefficient magnitudes in units of 1e-5.
    localparam int unsigned WYR = 29900;
    localparam int unsigned WYG = 58700;
    localparam int unsigned WYB = 11400;
    localparam int unsigned WUR = 14713;
    localparam int unsigned WUG = 28886;
    localparam int unsigned WUB = 43600;
    localparam int unsigned WVR = 61500;
    localparam int unsigned WVG = 51499;
    localparam int unsigned WVB = 10001;

    // Result of one lane: luma of its pixel and one chroma component.
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma;
    } lane_out_t;

    // Rounds a weight given in 1e-5 units to fixed point, ties rounded up.
    function automatic longint qcoef(input int unsigned k, input int frac);
        longint scaled;
        scaled = longint'(k) << frac;
        return (scaled + 64'sd50000) / 64'sd100000;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgb_to_yuv420_quad_converter.sv
// Top level of the 2x2 RGB to YUV 4:2:0 converter: skid stage, four lanes, merge.
//
//  channel   direction  tdata bits  transaction
//  s_axis    in         96          one 2x2 block of RGB pixels
//  m_axis    out        48          four luma bytes, one U, one V
//
// A block enters every clock cycle while the output side takes results.
// Three register stages (lane products, lane sum and clamp, merge register that
// drives m_tdata): a block accepted at the input passes through them in that order,
// and m_tvalid rises once the block reaches the merge register.
// The whole pipeline advances when the output register is empty or taken.
// A one-entry skid buffer at the input keeps s_tready a register output, so
// m_tready never reaches s_tready combinationally.
// Reset (rst_n low, asynchronous) empties the pipeline and the skid buffer.
`default_nettype none
`include "assert_macros.svh"

module rgb_to_yuv420_quad_converter #(
    parameter int COEF_FRAC_BITS = rgb2yuv_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0 up, 8 bits each: r_top_left, g_top_left, b_top_left,
    // r_top_right, g_top_right, b_top_right, r_bot_left, g_bot_left,
    // b_bot_left, r_bot_right, g_bot_right, b_bot_right.
    input  logic [rgb2yuv_pkg::IN_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0 up, 8 bits each: luma_top_left, luma_top_right,
    // luma_bot_left, luma_bot_right, chroma_u, chroma_v.
    output logic [rgb2yuv_pkg::OUT_W-1:0]   m_tdata
);

    localparam int PW = rgb2yuv_pkg::PIX_W;

    logic                         skid_full_reg, skid_full_next;
    logic [rgb2yuv_pkg::IN_W-1:0] skid_data_reg;
    logic                         mult_valid_reg, mult_valid_next;
    logic                         lane_valid_reg, lane_valid_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         pipe_adv;
    logic                         pipe_in_valid;
    logic [rgb2yuv_pkg::IN_W-1:0] pipe_in_data;
    logic                         s_accept;

    rgb2yuv_pkg::lane_out_t lane_tl, lane_tr, lane_bl, lane_br;

    // The pipeline moves as a unit whenever the output register can be refilled.
    assign pipe_adv      = !out_valid_reg || m_tready;
    assign s_tready      = !skid_full_reg;
    assign s_accept      = s_tvalid && s_tready;
    assign pipe_in_valid = skid_full_reg || s_tvalid;
    assign pipe_in_data  = skid_full_reg ? skid_data_reg : s_tdata;

    always_comb
    begin
        // A transaction taken during a stall parks in the skid buffer;
        // any advance drains it, since the buffer feeds the lanes first.
        if (pipe_adv)
            skid_full_next = 1'b0;
        else
            skid_full_next = skid_full_reg || s_accept;
        mult_valid_next = pipe_adv ? pipe_in_valid  : mult_valid_reg;
        lane_valid_next = pipe_adv ? mult_valid_reg : lane_valid_reg;
        out_valid_next  = pipe_adv ? lane_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg  <= 1'b0;
            mult_valid_reg <= 1'b0;
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            skid_full_reg  <= skid_full_next;
            mult_valid_reg <= mult_valid_next;
            lane_valid_reg <= lane_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && !pipe_adv)
            skid_data_reg <= s_tdata;
    end

    // Top lanes produce U, bottom lanes produce V.
    rgb2yuv_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .CHROMA_IS_U(1'b1)) u_lane_tl (
        .clk (clk),
        .en  (pipe_adv),
        .r   (pipe_in_data[0*PW +: PW]),
        .g   (pipe_in_data[1*PW +: PW]),
        .b   (pipe_in_data[2*PW +: PW]),
        .res (lane_tl)
    );

    rgb2yuv_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .CHROMA_IS_U(1'b1)) u_lane_tr (
        .clk (clk),
        .en  (pipe_adv),
        .r   (pipe_in_data[3*PW +: PW]),
        .g   (pipe_in_data[4*PW +: PW]),
        .b   (pipe_in_data[5*PW +: PW]),
        .res (lane_tr)
    );

    rgb2yuv_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .CHROMA_IS_U(1'b0)) u_lane_bl (
        .clk (clk),
        .en  (pipe_adv),
        .r   (pipe_in_data[6*PW +: PW]),
        .g   (pipe_in_data[7*PW +: PW]),
        .b   (pipe_in_data[8*PW +: PW]),
        .res (lane_bl)
    );

    rgb2yuv_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .CHROMA_IS_U(1'b0)) u_lane_br (
        .clk (clk),
        .en  (pipe_adv),
        .r   (pipe_in_data[9*PW +: PW]),
        .g   (pipe_in_data[10*PW +: PW]),
        .b   (pipe_in_data[11*PW +: PW]),
        .res (lane_br)
    );

    rgb2yuv_merge u_merge (
        .clk       (clk),
        .en        (pipe_adv),
        .top_left  (lane_tl),
        .top_right (lane_tr),
        .bot_left  (lane_bl),
        .bot_right (lane_br),
        .data      (m_tdata)
    );

    assign m_tvalid = out_valid_reg;

    // A transaction accepted during a stall must be held in the skid buffer.
    `ASSERT_NEXT(a_skid_catch, clk, rst_n, s_accept && !pipe_adv, skid_full_reg)
    // An advance always drains the skid buffer into the lanes.
    `ASSERT_NEXT(a_skid_drain, clk, rst_n, pipe_adv, !skid_full_reg)
    // A valid product stage moves into the lane result stage on an advance.
    `ASSERT_NEXT(a_stage_move, clk, rst_n, pipe_adv && mult_valid_reg, lane_valid_reg)

endmodule

`default_nettype wire

FILE: rtl/core/rgb2yuv_lane.sv
// One pixel lane: weighted sums for luma and one chroma component, two stages.
`default_nettype none

module rgb2yuv_lane #(
    parameter int COEF_FRAC_BITS = rgb2yuv_pkg::COEF_FRAC_BITS_DEF,
    parameter bit CHROMA_IS_U    = 1'b1
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]   r,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]   g,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]   b,
    output rgb2yuv_pkg::lane_out_t          res
);

    localparam int CW = COEF_FRAC_BITS;
    localparam int PW = CW + rgb2yuv_pkg::PIX_W;
    localparam int SW = CW + 11;

    localparam logic [CW-1:0] KYR = CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WYR, CW));
    localparam logic [CW-1:0] KYG = CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WYG, CW));
    localparam logic [CW-1:0] KYB = CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WYB, CW));
    localparam logic [CW-1:0] KCR = CHROMA_IS_U ?
        CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WUR, CW)) :
        CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WVR, CW));
    localparam logic [CW-1:0] KCG = CHROMA_IS_U ?
        CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WUG, CW)) :
        CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WVG, CW));
    localparam logic [CW-1:0] KCB = CHROMA_IS_U ?
        CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WUB, CW)) :
        CW'(rgb2yuv_pkg::qcoef(rgb2yuv_pkg::WVB, CW));
    localparam logic signed [SW-1:0] OFS = SW'(longint'(128) << CW);

    logic [PW-1:0] py_r_reg, py_g_reg, py_b_reg;
    logic [PW-1:0] pc_r_reg, pc_g_reg, pc_b_reg;
    logic signed [SW-1:0] sum_y, sum_c;
    logic signed [SW-1:0] ext_cr, ext_cg, ext_cb;
    rgb2yuv_pkg::lane_out_t res_reg, res_next;

    // Floors the fixed-point sum and clamps it to one byte.
    function automatic logic [7:0] floor_clamp(input logic signed [SW-1:0] s);
        logic [SW-1:0] q;
        q = $unsigned(s) >> CW;
        if (s[SW-1])
            return 8'd0;
        else if (|q[SW-1:8])
            return 8'hFF;
        else
            return q[7:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py_r_reg <= PW'(r * KYR);
            py_g_reg <= PW'(g * KYG);
            py_b_reg <= PW'(b * KYB);
            pc_r_reg <= PW'(r * KCR);
            pc_g_reg <= PW'(g * KCG);
            pc_b_reg <= PW'(b * KCB);
        end
    end

    always_comb
    begin
        ext_cr = $signed({{(SW-PW){1'b0}}, pc_r_reg});
        ext_cg = $signed({{(SW-PW){1'b0}}, pc_g_reg});
        ext_cb = $signed({{(SW-PW){1'b0}}, pc_b_reg});
        sum_y  = $signed({{(SW-PW){1'b0}}, py_r_reg})
               + $signed({{(SW-PW){1'b0}}, py_g_reg})
               + $signed({{(SW-PW){1'b0}}, py_b_reg});
        // U weighs blue positively, V weighs red positively; green is always subtracted.
        if (CHROMA_IS_U)
            sum_c = OFS - ext_cr - ext_cg + ext_cb;
        else
            sum_c = OFS + ext_cr - ext_cg - ext_cb;
        res_next.luma   = floor_clamp(sum_y);
        res_next.chroma = floor_clamp(sum_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rgb2yuv_merge.sv
// Merge stage: averages chroma of the lane pairs and packs the output word.
`default_nettype none

module rgb2yuv_merge (
    input  logic                            clk,
    input  logic                            en,
    input  rgb2yuv_pkg::lane_out_t          top_left,
    input  rgb2yuv_pkg::lane_out_t          top_right,
    input  rgb2yuv_pkg::lane_out_t          bot_left,
    input  rgb2yuv_pkg::lane_out_t          bot_right,
    output logic [rgb2yuv_pkg::OUT_W-1:0]   data
);

    logic [8:0] sum_u, sum_v;
    logic [rgb2yuv_pkg::OUT_W-1:0] data_reg, data_next;

    always_comb
    begin
        sum_u = {1'b0, top_left.chroma} + {1'b0, top_right.chroma};
        sum_v = {1'b0, bot_left.chroma} + {1'b0, bot_right.chroma};
        data_next = {sum_v[8:1], sum_u[8:1], bot_right.luma, bot_left.luma,
                     top_right.luma, top_left.luma};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: sim/tb_rgb_to_yuv420_quad_converter.sv
// Self-checking testbench for the 2x2 RGB to YUV 4:2:0 quad converter.
module tb_rgb_to_yuv420_quad_converter;

    localparam int FRAC       = rgb2yuv_pkg::COEF_FRAC_BITS_DEF;
    localparam int NUM_RANDOM = 1530;
    localparam int IDLE_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    // Fields of one result, declared from the top bit down so that the
    // packed layout matches m_tdata.
    typedef struct packed {
        bit [7:0] chroma_v;
        bit [7:0] chroma_u;
        bit [7:0] luma_bot_right;
        bit [7:0] luma_bot_left;
        bit [7:0] luma_top_right;
        bit [7:0] luma_top_left;
    } yuv_quad_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [rgb2yuv_pkg::IN_W-1:0]  s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [rgb2yuv_pkg::OUT_W-1:0] m_tdata;

    // Holds the expected YUV quads in acceptance order and checks each result
    // against the oldest one.
    class yuv_quad_scoreboard;
        yuv_quad_t expected_quads[$];
        int        mismatches;
        longint    kyr, kyg, kyb, kur, kug, kub, kvr, kvg, kvb, chroma_ofs;

        function new();
            mismatches = 0;
            kyr = fixed_weight(rgb2yuv_pkg::WYR);
            kyg = fixed_weight(rgb2yuv_pkg::WYG);
            kyb = fixed_weight(rgb2yuv_pkg::WYB);
            kur = fixed_weight(rgb2yuv_pkg::WUR);
            kug = fixed_weight(rgb2yuv_pkg::WUG);
            kub = fixed_weight(rgb2yuv_pkg::WUB);
            kvr = fixed_weight(rgb2yuv_pkg::WVR);
            kvg = fixed_weight(rgb2yuv_pkg::WVG);
            kvb = fixed_weight(rgb2yuv_pkg::WVB);
            chroma_ofs = longint'(128) << FRAC;
        endfunction

        // Weight given in units of 1e-5, scaled to fixed point with ties up.
        function longint fixed_weight(int unsigned k);
            return ((longint'(k) << FRAC) + 64'sd50000) / 64'sd100000;
        endfunction

        // Negative sums go to zero, the rest is floored and saturated.
        function bit [7:0] floor_sat(longint acc);
            if (acc < 0)
                return 8'd0;
            acc = acc >>> FRAC;
            if (acc > 255)
                return 8'd255;
            return acc[7:0];
        endfunction

        function yuv_quad_t convert_quad(bit [95:0] blk);
            yuv_quad_t q;
            bit [7:0]  lum [4];
            bit [8:0]  u_sum;
            bit [8:0]  v_sum;
            longint    r, g, b;
            u_sum = '0;
            v_sum = '0;
            for (int p = 0; p < 4; p++)
            begin
                r = longint'(blk[p*24 +: 8]);
                g = longint'(blk[p*24+8 +: 8]);
                b = longint'(blk[p*24+16 +: 8]);
                lum[p] = floor_sat(kyr*r + kyg*g + kyb*b);
                if (p < 2)
                    u_sum = u_sum + {1'b0, floor_sat(kub*b - kur*r - kug*g + chroma_ofs)};
                else
                    v_sum = v_sum + {1'b0, floor_sat(kvr*r - kvg*g - kvb*b + chroma_ofs)};
            end
            q.luma_top_left  = lum[0];
            q.luma_top_right = lum[1];
            q.luma_bot_left  = lum[2];
            q.luma_bot_right = lum[3];
            q.chroma_u       = u_sum[8:1];
            q.chroma_v       = v_sum[8:1];
            return q;
        endfunction

        function void note_block(bit [95:0] blk);
            expected_quads.push_back(convert_quad(blk));
        endfunction

        function void check_result(bit [47:0] data);
            bit [47:0] want;
            string     names [6] = '{"luma_top_left", "luma_top_right", "luma_bot_left",
                                     "luma_bot_right", "chroma_u", "chroma_v"};
            if (expected_quads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %h with no block pending", data);
                return;
            end
            want = expected_quads.pop_front();
            for (int f = 0; f < 6; f++)
            begin
                if (data[f*8 +: 8] !== want[f*8 +: 8])
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch on %s: expected %0d, got %0d", names[f],
                                 want[f*8 +: 8], data[f*8 +: 8]);
                end
            end
        endfunction

        function int pending();
            return expected_quads.size();
        endfunction
    endclass

    yuv_quad_scoreboard sb;
    int idle_cycles;
    int stall_mode;
    int mode_left;

    rgb_to_yuv420_quad_converter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pixel as it sits in s_tdata: red in the low byte, blue in the high one.
    function automatic bit [23:0] rgb(bit [7:0] r, bit [7:0] g, bit [7:0] b);
        return {b, g, r};
    endfunction

    function automatic bit [95:0] quad(bit [23:0] tl, bit [23:0] tr,
                                       bit [23:0] bl, bit [23:0] br);
        return {br, bl, tr, tl};
    endfunction

    // Random block that leans on the ends of the byte range so that the
    // clamps are hit often; some blocks use only fully saturated channels.
    function automatic bit [95:0] random_block();
        bit [95:0] blk;
        bit        saturated;
        saturated = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < 12; i++)
        begin
            if (saturated)
                blk[i*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
            begin
                case ($urandom_range(0, 9))
                    0:       blk[i*8 +: 8] = 8'h00;
                    1:       blk[i*8 +: 8] = 8'hFF;
                    2:       blk[i*8 +: 8] = 8'($urandom_range(0, 3));
                    3:       blk[i*8 +: 8] = 8'($urandom_range(252, 255));
                    default: blk[i*8 +: 8] = 8'($urandom_range(0, 255));
                endcase
            end
        end
        return blk;
    endfunction

    // Offers one block and returns at the edge where the transaction happens.
    task automatic send_block(input bit [95:0] blk);
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Output side: switches between always ready, light stalls and heavy
    // stalls, each held for a random stretch of cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(32, 200);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Transactions are sampled with the values from before the edge. The
    // watchdog ends the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_block(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        bit [95:0] directed [$];
        bit [95:0] blk;
        int        burst_left;
        int        total;
        sb          = new();
        idle_cycles = 0;
        stall_mode  = 0;
        mode_left   = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;

        // Field extremes, primaries, and blocks that drive luma to full
        // scale and the V chroma sum below zero and past 255.
        directed.push_back('0);
        directed.push_back({96{1'b1}});
        directed.push_back(quad(rgb(255, 0, 0), rgb(255, 0, 0), rgb(255, 0, 0), rgb(255, 0, 0)));
        directed.push_back(quad(rgb(0, 255, 0), rgb(0, 255, 0), rgb(0, 255, 0), rgb(0, 255, 0)));
        directed.push_back(quad(rgb(0, 0, 255), rgb(0, 0, 255), rgb(0, 0, 255), rgb(0, 0, 255)));
        directed.push_back(quad(rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255),
                                rgb(255, 255, 255)));
        directed.push_back(quad(rgb(255, 255, 0), rgb(255, 255, 0), rgb(0, 255, 255),
                                rgb(0, 255, 255)));
        directed.push_back(quad(rgb(0, 0, 255), rgb(0, 0, 255), rgb(255, 0, 0),
                                rgb(255, 0, 0)));
        directed.push_back(quad(rgb(255, 255, 0), rgb(0, 0, 255), rgb(255, 0, 255),
                                rgb(0, 255, 0)));
        directed.push_back(quad(rgb(255, 0, 255), rgb(0, 255, 255), rgb(255, 255, 0),
                                rgb(0, 0, 0)));
        directed.push_back({12{8'hAA}});
        directed.push_back({12{8'h55}});
        directed.push_back({12{8'h01}});
        directed.push_back({12{8'hFE}});
        directed.push_back({12{8'h80}});
        directed.push_back({12{8'h7F}});
        directed.push_back(quad(rgb(254, 255, 255), rgb(255, 254, 255), rgb(1, 0, 0),
                                rgb(0, 1, 1)));
        directed.push_back(quad(rgb(0, 0, 0), rgb(255, 255, 255), rgb(255, 255, 255),
                                rgb(0, 0, 0)));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        total      = directed.size() + NUM_RANDOM;
        burst_left = $urandom_range(1, 60);
        for (int i = 0; i < total; i++)
        begin
            if (i < directed.size())
                blk = directed[i];
            else
                blk = random_block();
            send_block(blk);
            burst_left--;
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 60);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rgb2yuv_pkg.sv
rtl/core/rgb2yuv_lane.sv
rtl/core/rgb2yuv_merge.sv
rtl/core/rgb_to_yuv420_quad_converter.sv
sim/tb_rgb_to_yuv420_quad_converter.sv
